[rtl/core/cmtr_pkg.sv]
package cmtr_pkg;

    // Event and angle format
    localparam int MAX_JETS  = 16;
    localparam int CNT_W     = $clog2(MAX_JETS + 1);
    localparam int IDX_W     = 5;
    localparam int ETA_W     = 14;
    localparam int PHI_W     = 13;
    localparam int PT_W      = 16;
    localparam int MASS_W    = 16;
    localparam int CONE_W    = 28;
    localparam int DE2_W     = 28;
    localparam int DP2_W     = 24;
    localparam int D2_W      = 29;

    // pi and 2*pi with 10 fractional bits
    localparam int FP_PI     = 3217;
    localparam int FP_TWO_PI = 6434;

    localparam logic [CONE_W-1:0] CONE_R2_RESET = CONE_W'(167772);

    // Stream widths, padded to whole bytes
    localparam int IN_BITS   = 3 * ETA_W + 3 * PHI_W + PT_W + MASS_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * IDX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Squared-distance terms of one jet, carried from the front to the match stage
    typedef struct packed {
        logic [DE2_W-1:0] de2_1;
        logic [DP2_W-1:0] dp2_1;
        logic [DE2_W-1:0] de2_2;
        logic [DP2_W-1:0] dp2_2;
        logic [PT_W-1:0]  pt;
        logic             mass_ok;
        logic             last;
    } cmtr_item_t;

    // Map a match slot to the output index code; all ones means unmatched
    function automatic logic [IDX_W-1:0] out_index(input logic vld,
                                                   input logic [CNT_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = vld ? IDX_W'(idx) : {IDX_W{1'b1}};
        return r;
    endfunction

endpackage

[rtl/core/cmtr_front.sv]
module cmtr_front
    import cmtr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 in_last,
    output logic                 item_valid,
    input  logic                 item_ready,
    output cmtr_item_t           item
);

    logic                 s1_valid_reg;
    logic [IN_DATA_W-1:0] s1_data_reg;
    logic                 s1_last_reg;
    logic                 s2_valid_reg;
    cmtr_item_t           s2_item_reg;
    cmtr_item_t           s2_item_next;
    logic                 s1_adv;
    logic                 s2_adv;

    logic signed [ETA_W-1:0]  r1_eta, r2_eta, j_eta;
    logic signed [PHI_W-1:0]  r1_phi, r2_phi, j_phi;
    logic        [PT_W-1:0]   j_pt;
    logic signed [MASS_W-1:0] j_mass;

    // Phi difference wrapped into [-pi, pi); one correction covers the input range
    function automatic logic signed [PHI_W-1:0] dphi_wrap(input logic signed [PHI_W-1:0] a,
                                                          input logic signed [PHI_W-1:0] b);
        logic signed [PHI_W:0] d;
        logic signed [PHI_W:0] w;
        d = (PHI_W+1)'(a) - (PHI_W+1)'(b);
        if (d >= (PHI_W+1)'(FP_PI))
            w = d - (PHI_W+1)'(FP_TWO_PI);
        else if (d < -(PHI_W+1)'(FP_PI))
            w = d + (PHI_W+1)'(FP_TWO_PI);
        else
            w = d;
        return w[PHI_W-1:0];
    endfunction

    function automatic logic [DE2_W-1:0] eta_sq(input logic signed [ETA_W-1:0] a,
                                                input logic signed [ETA_W-1:0] b);
        logic signed [ETA_W:0]       d;
        logic signed [2*ETA_W+1:0]   p;
        d = (ETA_W+1)'(a) - (ETA_W+1)'(b);
        p = d * d;
        return p[DE2_W-1:0];
    endfunction

    function automatic logic [DP2_W-1:0] phi_sq(input logic signed [PHI_W-1:0] d);
        logic signed [2*PHI_W-1:0] p;
        p = d * d;
        return p[DP2_W-1:0];
    endfunction

    // Stage advance: each stage moves when its successor has room
    assign s2_adv   = !s2_valid_reg || item_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Unpack the held transaction
    assign r1_eta = s1_data_reg[13:0];
    assign r1_phi = s1_data_reg[26:14];
    assign r2_eta = s1_data_reg[40:27];
    assign r2_phi = s1_data_reg[53:41];
    assign j_pt   = s1_data_reg[69:54];
    assign j_eta  = s1_data_reg[83:70];
    assign j_phi  = s1_data_reg[96:84];
    assign j_mass = s1_data_reg[112:97];

    // Square the coordinate differences for both references
    always_comb
    begin
        s2_item_next.de2_1   = eta_sq(j_eta, r1_eta);
        s2_item_next.dp2_1   = phi_sq(dphi_wrap(j_phi, r1_phi));
        s2_item_next.de2_2   = eta_sq(j_eta, r2_eta);
        s2_item_next.dp2_2   = phi_sq(dphi_wrap(j_phi, r2_phi));
        s2_item_next.pt      = j_pt;
        s2_item_next.mass_ok = !j_mass[MASS_W-1] && (|j_mass);
        s2_item_next.last    = s1_last_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_data_reg <= in_data;
            s1_last_reg <= in_last;
        end
        if (s2_adv && s1_valid_reg)
            s2_item_reg <= s2_item_next;
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

[rtl/core/cmtr_match.sv]
module cmtr_match
    import cmtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CONE_W-1:0]     cfg_wdata,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  cmtr_item_t            item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [CONE_W-1:0] cone_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              a_vld_reg, b_vld_reg;
    logic [CNT_W-1:0]  a_idx_reg, b_idx_reg;
    logic [PT_W-1:0]   a_pt_reg, b_pt_reg;
    logic              a_vld_next, b_vld_next;
    logic [CNT_W-1:0]  a_idx_next, b_idx_next;
    logic [PT_W-1:0]   a_pt_next, b_pt_next;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  first_reg, second_reg;

    logic [D2_W-1:0]   d2_1, d2_2;
    logic              hit1, hit2, active, in_range, a_hit, b_hit, swap, fire;
    logic              a_vld_m, b_vld_m;
    logic [CNT_W-1:0]  a_idx_m, b_idx_m;
    logic [PT_W-1:0]   a_pt_m, b_pt_m;

    // A last jet needs the result slot free; other jets always move on
    assign item_ready = !item.last || !out_valid_reg || out_ready;
    assign fire       = item_valid && item_ready;

    // Cone tests
    assign d2_1 = D2_W'(item.de2_1) + D2_W'(item.dp2_1);
    assign d2_2 = D2_W'(item.de2_2) + D2_W'(item.dp2_2);
    assign hit1 = d2_1 < D2_W'(cone_reg);
    assign hit2 = d2_2 < D2_W'(cone_reg);

    assign in_range = cnt_reg < CNT_W'(MAX_JETS);
    assign active   = item.mass_ok && in_range && !(a_vld_reg && b_vld_reg);
    assign a_hit    = active && !a_vld_reg && hit1;
    assign b_hit    = active && !b_vld_reg && hit2;

    // Record first matches, then order them by pt
    always_comb
    begin
        a_vld_m = a_vld_reg || a_hit;
        a_idx_m = a_hit ? cnt_reg : a_idx_reg;
        a_pt_m  = a_hit ? item.pt : a_pt_reg;
        b_vld_m = b_vld_reg || b_hit;
        b_idx_m = b_hit ? cnt_reg : b_idx_reg;
        b_pt_m  = b_hit ? item.pt : b_pt_reg;
        swap    = active && a_vld_m && b_vld_m && (b_pt_m > a_pt_m);
        if (swap)
        begin
            a_vld_next = b_vld_m;
            a_idx_next = b_idx_m;
            a_pt_next  = b_pt_m;
            b_vld_next = a_vld_m;
            b_idx_next = a_idx_m;
            b_pt_next  = a_pt_m;
        end
        else
        begin
            a_vld_next = a_vld_m;
            a_idx_next = a_idx_m;
            a_pt_next  = a_pt_m;
            b_vld_next = b_vld_m;
            b_idx_next = b_idx_m;
            b_pt_next  = b_pt_m;
        end
        cnt_next = in_range ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // Cone register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cone_reg <= CONE_R2_RESET;
        else if (cfg_we)
            cone_reg <= cfg_wdata;
    end

    // Event state; clear after the last jet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            a_vld_reg <= 1'b0;
            a_idx_reg <= '0;
            a_pt_reg  <= '0;
            b_vld_reg <= 1'b0;
            b_idx_reg <= '0;
            b_pt_reg  <= '0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                cnt_reg   <= '0;
                a_vld_reg <= 1'b0;
                a_idx_reg <= '0;
                a_pt_reg  <= '0;
                b_vld_reg <= 1'b0;
                b_idx_reg <= '0;
                b_pt_reg  <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                a_vld_reg <= a_vld_next;
                a_idx_reg <= a_idx_next;
                a_pt_reg  <= a_pt_next;
                b_vld_reg <= b_vld_next;
                b_idx_reg <= b_idx_next;
                b_pt_reg  <= b_pt_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && item.last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            first_reg  <= out_index(a_vld_next, a_idx_next);
            second_reg <= out_index(b_vld_next, b_idx_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'({second_reg, first_reg});

endmodule

[rtl/core/cone_match_two_references.sv]
// Cone matching of an event's jets against two reference particles.
//
// Input stream (s_axis): one jet per transaction, carrying both reference
// positions; s_axis_tlast marks the last jet of the event. Jets with mass
// not above zero are skipped; jets past MAX_JETS are ignored.
// Output stream (m_axis): one transaction per event, sent for its last jet,
// with the two matched jet indices (all ones when a reference is unmatched).
// Configuration: cfg_we writes the squared cone radius from cfg_wdata;
// write it only while no event is in flight.
//
// Throughput: one jet per cycle while the result register is not held. A last jet
// accepted on s_axis passes the input register, the squaring register and
// the result register before its result shows on m_axis.
// Reset: all stages empty, event state cleared, cone radius back to 0.4.
// Stall: while the result register is held, non-last jets keep flowing;
// a last jet waits in place and the input backs up behind it.
module cone_match_two_references
    import cmtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ref1_eta, ref1_phi, ref2_eta, ref2_phi, jet_pt, jet_eta, jet_phi, mass code
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // first_index, second_index
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CONE_W-1:0]     cfg_wdata
);

    logic       item_valid;
    logic       item_ready;
    cmtr_item_t item;

    cmtr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    cmtr_match u_match
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule
